@@ rtl/core/bptc_pkg.sv @@
// ----------------------------------------------------------------------------
// bptc_pkg
// Shared types and constants for the barometric compensation pipeline.
// ----------------------------------------------------------------------------
package bptc_pkg;

    localparam int unsigned TEMP_DEPTH  = 5;
    localparam int unsigned FRONT_DEPTH = 7;
    localparam int unsigned DIV_BITS    = 64;
    localparam int unsigned DIV_DEPTH   = DIV_BITS + 2;
    localparam int unsigned BACK_DEPTH  = 6;
    localparam int unsigned PIPE_DEPTH  = TEMP_DEPTH + FRONT_DEPTH + DIV_DEPTH + BACK_DEPTH;

    localparam logic [1:0] CFG_TEMP_CAL   = 2'd0;
    localparam logic [1:0] CFG_PRESS_LOW  = 2'd1;
    localparam logic [1:0] CFG_PRESS_HIGH = 2'd2;
    localparam logic [1:0] CFG_PRESS_LAST = 2'd3;

    localparam logic signed [25:0] FINE_OFFSET  = 26'sd128000;
    localparam logic [20:0]        PRESS_FULL   = 21'd1048576;
    localparam logic [11:0]        NUM_SCALE    = 12'd3125;
    localparam logic [63:0]        DEN_BIAS     = 64'h0000_8000_0000_0000;
    localparam logic [24:0]        PRESS_MAX    = 25'h1FF_FFFF;
    localparam logic [15:0]        HPA_RECIP    = 16'd41944;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } cal_t;

    typedef struct packed {
        logic signed [15:0] tc;
        logic signed [31:0] fine;
    } side_t;

endpackage

@@ rtl/core/bptc_temp.sv @@
// ----------------------------------------------------------------------------
// bptc_temp
// Five-stage temperature path: fine temperature and centi-degree value.
// ----------------------------------------------------------------------------
module bptc_temp (
    input  logic           clk,
    input  logic           en,
    input  bptc_pkg::cal_t cal,
    input  logic [19:0]    raw_t,
    output bptc_pkg::side_t side
);
    import bptc_pkg::*;

    logic signed [18:0] x_reg,    x_next;
    logic signed [17:0] d_reg,    d_next;
    logic signed [34:0] m1_reg,   m1_next;
    logic signed [35:0] dd_reg,   dd_next;
    logic signed [23:0] a1_reg,   a1_next;
    logic signed [36:0] m2_reg,   m2_next;
    logic signed [31:0] fine_reg, fine_next;
    side_t              side_reg, side_next;

    logic signed [34:0] sh1;
    logic signed [35:0] sh_dd;
    logic signed [20:0] e21;
    logic signed [36:0] sh2;
    logic signed [33:0] fw;
    logic signed [33:0] tw;

    always_comb
    begin
        x_next  = $signed({2'b00, raw_t[19:3]}) - $signed({2'b00, cal.t1, 1'b0});
        d_next  = $signed({2'b00, raw_t[19:4]}) - $signed({2'b00, cal.t1});
        m1_next = x_reg * cal.t2;
        dd_next = d_reg * d_reg;
        sh1     = m1_reg >>> 11;
        a1_next = $signed(sh1[23:0]);
        sh_dd   = dd_reg >>> 12;
        e21     = $signed(sh_dd[20:0]);
        m2_next = e21 * cal.t3;
        sh2     = m2_reg >>> 14;
        fine_next = $signed({{8{a1_reg[23]}}, a1_reg}) + $signed(sh2[31:0]);
        fw = $signed({{2{fine_reg[31]}}, fine_reg});
        tw = ((fw <<< 2) + fw + 34'sd128) >>> 8;
        side_next.fine = fine_reg;
        if (tw < -34'sd32768)
        begin
            side_next.tc = -16'sd32768;
        end
        else if (tw > 34'sd32767)
        begin
            side_next.tc = 16'sd32767;
        end
        else
        begin
            side_next.tc = $signed(tw[15:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            d_reg    <= d_next;
            m1_reg   <= m1_next;
            dd_reg   <= dd_next;
            a1_reg   <= a1_next;
            m2_reg   <= m2_next;
            fine_reg <= fine_next;
            side_reg <= side_next;
        end
    end

    assign side = side_reg;

endmodule

@@ rtl/core/bptc_pfront.sv @@
// ----------------------------------------------------------------------------
// bptc_pfront
// Seven-stage pressure front end: builds the 64-bit dividend and divisor.
// ----------------------------------------------------------------------------
module bptc_pfront (
    input  logic               clk,
    input  logic               en,
    input  bptc_pkg::cal_t     cal,
    input  bptc_pkg::side_t    side_in,
    input  logic [19:0]        raw_p,
    output logic signed [63:0] num,
    output logic signed [63:0] den,
    output bptc_pkg::side_t    side_out
);
    import bptc_pkg::*;

    logic signed [25:0] av_reg,   av_next;
    logic        [20:0] pw_reg [0:4];
    logic        [20:0] pw_next;
    logic signed [51:0] aa_reg,   aa_next;
    logic signed [41:0] ap5_reg [0:1];
    logic signed [41:0] ap5_next;
    logic signed [41:0] ap2_reg [0:1];
    logic signed [41:0] ap2_next;
    logic signed [63:0] b6_reg,   b6_next;
    logic signed [63:0] b3_reg,   b3_next;
    logic        [63:0] bsum_reg, bsum_next;
    logic        [63:0] asum_reg, asum_next;
    logic        [47:0] plo_reg,  plo_next;
    logic        [31:0] phi_reg,  phi_next;
    logic        [63:0] num1_reg, num1_next;
    logic signed [63:0] den_reg,  den_next;
    logic signed [63:0] den2_reg;
    logic        [43:0] nlo_reg,  nlo_next;
    logic        [31:0] nhi_reg,  nhi_next;
    logic signed [63:0] num_reg,  num_next;
    side_t              side_reg [0:FRONT_DEPTH-1];

    logic signed [67:0] b6w;
    logic signed [67:0] b3w;
    logic        [47:0] phi_full;
    logic        [63:0] prod;
    logic        [43:0] nh_full;

    always_comb
    begin
        av_next  = $signed(side_in.fine[25:0]) - FINE_OFFSET;
        pw_next  = PRESS_FULL - {1'b0, raw_p};
        aa_next  = av_reg * av_reg;
        ap5_next = av_reg * cal.p5;
        ap2_next = av_reg * cal.p2;
        b6w      = aa_reg * cal.p6;
        b3w      = aa_reg * cal.p3;
        b6_next  = b6w[63:0];
        b3_next  = b3w[63:0];
        bsum_next = b6_reg
                  + ({{22{ap5_reg[1][41]}}, ap5_reg[1]} << 17)
                  + ({{48{cal.p4[15]}}, cal.p4} << 35);
        asum_next = 64'(b3_reg >>> 8)
                  + ({{22{ap2_reg[1][41]}}, ap2_reg[1]} << 12)
                  + DEN_BIAS;
        plo_next  = asum_reg[31:0] * cal.p1;
        phi_full  = asum_reg[63:32] * cal.p1;
        phi_next  = phi_full[31:0];
        num1_next = {12'b0, pw_reg[3], 31'b0} - bsum_reg;
        prod      = {16'b0, plo_reg} + {phi_reg, 32'b0};
        den_next  = $signed(prod) >>> 33;
        nlo_next  = num1_reg[31:0] * NUM_SCALE;
        nh_full   = num1_reg[63:32] * NUM_SCALE;
        nhi_next  = nh_full[31:0];
        num_next  = $signed({20'b0, nlo_reg} + {nhi_reg, 32'b0});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            av_reg     <= av_next;
            pw_reg[0]  <= pw_next;
            aa_reg     <= aa_next;
            ap5_reg[0] <= ap5_next;
            ap2_reg[0] <= ap2_next;
            b6_reg     <= b6_next;
            b3_reg     <= b3_next;
            ap5_reg[1] <= ap5_reg[0];
            ap2_reg[1] <= ap2_reg[0];
            bsum_reg   <= bsum_next;
            asum_reg   <= asum_next;
            plo_reg    <= plo_next;
            phi_reg    <= phi_next;
            num1_reg   <= num1_next;
            den_reg    <= den_next;
            nlo_reg    <= nlo_next;
            nhi_reg    <= nhi_next;
            num_reg    <= num_next;
            den2_reg   <= den_reg;
            for (int i = 1; i < 5; i++)
            begin
                pw_reg[i] <= pw_reg[i-1];
            end
            side_reg[0] <= side_in;
            for (int i = 1; i < FRONT_DEPTH; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign num      = num_reg;
    assign den      = den2_reg;
    assign side_out = side_reg[FRONT_DEPTH-1];

endmodule

@@ rtl/core/bptc_div.sv @@
// ----------------------------------------------------------------------------
// bptc_div
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating.
// ----------------------------------------------------------------------------
module bptc_div (
    input  logic               clk,
    input  logic               en,
    input  logic signed [63:0] num,
    input  logic signed [63:0] den,
    input  bptc_pkg::side_t    side_in,
    output logic signed [63:0] quo,
    output logic               zero_den,
    output bptc_pkg::side_t    side_out
);
    import bptc_pkg::*;

    logic [2*DIV_BITS-1:0] acc_reg [0:DIV_BITS];
    logic [DIV_BITS-1:0]   dv_reg  [0:DIV_BITS];
    logic                  neg_reg [0:DIV_BITS];
    logic                  bad_reg [0:DIV_BITS];
    side_t                 side_reg [0:DIV_BITS];

    logic [DIV_BITS-1:0]   un_next;
    logic [DIV_BITS-1:0]   ud_next;
    logic signed [63:0]    quo_reg, quo_next;
    logic                  zd_reg;
    side_t                 sout_reg;

    always_comb
    begin
        un_next  = num[63] ? (64'd0 - num) : num;
        ud_next  = den[63] ? (64'd0 - den) : den;
        quo_next = neg_reg[DIV_BITS] ? $signed(64'd0 - acc_reg[DIV_BITS][DIV_BITS-1:0])
                                     : $signed(acc_reg[DIV_BITS][DIV_BITS-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg[0]  <= {{DIV_BITS{1'b0}}, un_next};
            dv_reg[0]   <= ud_next;
            neg_reg[0]  <= num[63] ^ den[63];
            bad_reg[0]  <= (den == 64'sd0);
            side_reg[0] <= side_in;
            quo_reg     <= quo_next;
            zd_reg      <= bad_reg[DIV_BITS];
            sout_reg    <= side_reg[DIV_BITS];
        end
    end

    for (genvar k = 1; k <= DIV_BITS; k++)
    begin : g_step
        logic [2*DIV_BITS-1:0] sh;
        logic [2*DIV_BITS-1:0] acc_next;

        always_comb
        begin
            sh = {acc_reg[k-1][2*DIV_BITS-2:0], 1'b0};
            if (sh[2*DIV_BITS-1:DIV_BITS] >= dv_reg[k-1])
            begin
                acc_next = {sh[2*DIV_BITS-1:DIV_BITS] - dv_reg[k-1],
                            sh[DIV_BITS-1:1], 1'b1};
            end
            else
            begin
                acc_next = sh;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                acc_reg[k]  <= acc_next;
                dv_reg[k]   <= dv_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                bad_reg[k]  <= bad_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign quo      = quo_reg;
    assign zero_den = zd_reg;
    assign side_out = sout_reg;

endmodule

@@ rtl/core/bptc_pback.sv @@
// ----------------------------------------------------------------------------
// bptc_pback
// Six-stage pressure back end: correction terms, saturation and hPa value.
// ----------------------------------------------------------------------------
module bptc_pback (
    input  logic               clk,
    input  logic               en,
    input  bptc_pkg::cal_t     cal,
    input  logic signed [63:0] quo,
    input  logic               zero_den,
    input  bptc_pkg::side_t    side_in,
    output bptc_pkg::side_t    side_out,
    output logic [24:0]        press_fixed,
    output logic [10:0]        press_hpa,
    output logic               press_bad
);
    import bptc_pkg::*;

    logic signed [63:0] q_reg [0:2];
    logic signed [50:0] s_reg,    s_next;
    logic        [63:0] m9_reg,   m9_next;
    logic        [63:0] p8q_reg,  p8q_next;
    logic        [63:0] pp0_reg,  pp0_next;
    logic        [31:0] cr_reg,   cr_next;
    logic signed [63:0] bq_reg [0:1];
    logic signed [63:0] bq_next;
    logic signed [63:0] a9_reg,   a9_next;
    logic        [63:0] sum_reg,  sum_next;
    logic        [24:0] pf_reg,   pf_next;
    logic        [24:0] pf2_reg;
    logic        [10:0] hpa_reg,  hpa_next;
    logic               bad_reg  [0:BACK_DEPTH-1];
    side_t              side_reg [0:BACK_DEPTH-1];

    logic signed [63:0] sq;
    logic signed [79:0] m9w;
    logic signed [79:0] p8w;
    logic        [63:0] s64;
    logic        [31:0] c1;
    logic        [31:0] c2;
    logic signed [63:0] pr;
    logic        [30:0] hw;

    always_comb
    begin
        sq       = quo >>> 13;
        s_next   = $signed(sq[50:0]);
        m9w      = sq * cal.p9;
        m9_next  = m9w[63:0];
        p8w      = quo * cal.p8;
        p8q_next = p8w[63:0];
        s64      = {{13{s_reg[50]}}, s_reg};
        pp0_next = m9_reg[31:0] * s64[31:0];
        c1       = m9_reg[31:0] * s64[63:32];
        c2       = m9_reg[63:32] * s64[31:0];
        cr_next  = c1 + c2;
        bq_next  = $signed(p8q_reg) >>> 19;
        a9_next  = $signed(pp0_reg + {cr_reg, 32'b0}) >>> 25;
        sum_next = q_reg[2] + a9_reg + bq_reg[1];
        pr       = ($signed(sum_reg) >>> 8) + $signed({{44{cal.p7[15]}}, cal.p7, 4'b0});
        if (bad_reg[3] || pr[63])
        begin
            pf_next = '0;
        end
        else if (pr > $signed({39'b0, PRESS_MAX}))
        begin
            pf_next = PRESS_MAX;
        end
        else
        begin
            pf_next = pr[24:0];
        end
        hw       = pf_reg[24:10] * HPA_RECIP;
        hpa_next = hw[30:20];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg[0]  <= quo;
            q_reg[1]  <= q_reg[0];
            q_reg[2]  <= q_reg[1];
            s_reg     <= s_next;
            m9_reg    <= m9_next;
            p8q_reg   <= p8q_next;
            pp0_reg   <= pp0_next;
            cr_reg    <= cr_next;
            bq_reg[0] <= bq_next;
            bq_reg[1] <= bq_reg[0];
            a9_reg    <= a9_next;
            sum_reg   <= sum_next;
            pf_reg    <= pf_next;
            pf2_reg   <= pf_reg;
            hpa_reg   <= hpa_next;
            bad_reg[0]  <= zero_den;
            side_reg[0] <= side_in;
            for (int i = 1; i < BACK_DEPTH; i++)
            begin
                bad_reg[i]  <= bad_reg[i-1];
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign side_out    = side_reg[BACK_DEPTH-1];
    assign press_fixed = pf2_reg;
    assign press_hpa   = hpa_reg;
    assign press_bad   = bad_reg[BACK_DEPTH-1];

endmodule

@@ rtl/core/baro_temp_pressure_compensation_core.sv @@
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_core
// Temperature and pressure compensation pipeline with calibration registers.
//
//   port group   direction  word contents
//   s_t*         in         raw temperature/pressure pair
//   m_t*         out        compensated temperature and pressure
//   cfg_*        in         calibration register writes
//
// Words pass through the temperature path, pressure front end, divider and
// back end; the divider is the deepest section. One word enters per cycle
// unless the output stalls; a stalled output word holds the whole pipeline
// and nothing is dropped. Reset clears valid bits and calibration registers.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // raw_temperature, raw_pressure
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // temperature_centi, fine_temperature,
                                   // pressure_fixed, pressure_hpa, zero pad
    output logic [0:0]  m_tuser,   // pressure_invalid
    input  logic        cfg_wen,
    input  logic [1:0]  cfg_idx,
    input  logic [63:0] cfg_wdata
);
    import bptc_pkg::*;

    logic [47:0]           tcal_reg;
    logic [63:0]           pcl_reg;
    logic [63:0]           pch_reg;
    logic [15:0]           pl_reg;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [19:0]           rawp_reg [0:TEMP_DEPTH-1];
    logic                  en;
    cal_t                  cal;

    side_t              side_t_o;
    side_t              side_f_o;
    side_t              side_d_o;
    side_t              side_b_o;
    logic signed [63:0] num;
    logic signed [63:0] den;
    logic signed [63:0] quo;
    logic               zero_den;
    logic [24:0]        press_fixed;
    logic [10:0]        press_hpa;
    logic               press_bad;

    assign en       = ~vld_reg[PIPE_DEPTH-1] | m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[PIPE_DEPTH-1];

    always_comb
    begin
        cal.t1 = tcal_reg[15:0];
        cal.t2 = $signed(tcal_reg[31:16]);
        cal.t3 = $signed(tcal_reg[47:32]);
        cal.p1 = pcl_reg[15:0];
        cal.p2 = $signed(pcl_reg[31:16]);
        cal.p3 = $signed(pcl_reg[47:32]);
        cal.p4 = $signed(pcl_reg[63:48]);
        cal.p5 = $signed(pch_reg[15:0]);
        cal.p6 = $signed(pch_reg[31:16]);
        cal.p7 = $signed(pch_reg[47:32]);
        cal.p8 = $signed(pch_reg[63:48]);
        cal.p9 = $signed(pl_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tcal_reg <= '0;
            pcl_reg  <= '0;
            pch_reg  <= '0;
            pl_reg   <= '0;
        end
        else if (cfg_wen)
        begin
            case (cfg_idx)
                CFG_TEMP_CAL:   tcal_reg <= cfg_wdata[47:0];
                CFG_PRESS_LOW:  pcl_reg  <= cfg_wdata;
                CFG_PRESS_HIGH: pch_reg  <= cfg_wdata;
                CFG_PRESS_LAST: pl_reg   <= cfg_wdata[15:0];
                default:        pl_reg   <= pl_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], s_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rawp_reg[0] <= s_tdata[39:20];
            for (int i = 1; i < TEMP_DEPTH; i++)
            begin
                rawp_reg[i] <= rawp_reg[i-1];
            end
        end
    end

    bptc_temp u_temp (
        .clk   (clk),
        .en    (en),
        .cal   (cal),
        .raw_t (s_tdata[19:0]),
        .side  (side_t_o)
    );

    bptc_pfront u_pfront (
        .clk      (clk),
        .en       (en),
        .cal      (cal),
        .side_in  (side_t_o),
        .raw_p    (rawp_reg[TEMP_DEPTH-1]),
        .num      (num),
        .den      (den),
        .side_out (side_f_o)
    );

    bptc_div u_div (
        .clk      (clk),
        .en       (en),
        .num      (num),
        .den      (den),
        .side_in  (side_f_o),
        .quo      (quo),
        .zero_den (zero_den),
        .side_out (side_d_o)
    );

    bptc_pback u_pback (
        .clk         (clk),
        .en          (en),
        .cal         (cal),
        .quo         (quo),
        .zero_den    (zero_den),
        .side_in     (side_d_o),
        .side_out    (side_b_o),
        .press_fixed (press_fixed),
        .press_hpa   (press_hpa),
        .press_bad   (press_bad)
    );

    assign m_tdata = {4'b0, press_hpa, press_fixed, side_b_o.fine, side_b_o.tc};
    assign m_tuser = press_bad;

endmodule
